@@ hdl/kss_pkg.sv @@
// kss_pkg: types and constants shared by the k-sorted stream sorter.
// Holds the value type, the controller state enum and the command/status
// structs that join the controller and the datapath. No dependencies.
`default_nettype none

package kss_pkg;

  localparam int ValueWidth = 32;
  localparam int MdWidth    = 4;
  localparam logic [MdWidth-1:0] MdReset = 4'd1;

  // register word index (paddr[2])
  localparam logic RegMaxDistance = 1'b0;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP_RD,
    ST_POP_LD,
    ST_SD_RD,
    ST_SD_CMP,
    ST_PUSH,
    ST_SU_RD,
    ST_SU_CMP
  } state_e;

  typedef struct packed {
    logic load_item;
    logic pop_read;
    logic pop_load;
    logic drain;
    logic sd_read;
    logic sd_step;
    logic push_init;
    logic su_read;
    logic su_step;
    logic wr_x;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_pop;
    logic count_zero;
    logic sd_leaf;
    logic sd_swap;
    logic su_root;
    logic su_swap;
    logic out_free;
    logic item_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/kss_in_if.sv @@
// kss_in_if: valid/ready channel carrying one input stream element.
// Depends on kss_pkg for the value type.
`default_nettype none

interface kss_in_if;
  logic            valid;
  logic            ready;
  kss_pkg::value_t item_value;
  logic            item_last;

  modport source (output valid, output item_value, output item_last, input ready);
  modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

`default_nettype wire

@@ hdl/kss_out_if.sv @@
// kss_out_if: valid/ready channel carrying one sorted result.
// Depends on kss_pkg for the value type.
`default_nettype none

interface kss_out_if;
  logic            valid;
  logic            ready;
  kss_pkg::value_t sorted_value;
  logic            sorted_last;

  modport source (output valid, output sorted_value, output sorted_last, input ready);
  modport sink   (input valid, input sorted_value, input sorted_last, output ready);
endinterface

`default_nettype wire

@@ hdl/kss_dp.sv @@
// kss_dp: heap datapath: heap memory with two registered read ports,
// moving-value and index registers, entry count and result register.
// Depends on kss_pkg; driven by commands from kss_ctrl.
`default_nettype none

module kss_dp #(
  parameter int MAX_DISTANCE = 15
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire kss_pkg::ctrl_cmd_t             cmd_i,
  output kss_pkg::dp_stat_t                   stat_o,
  input  wire logic [kss_pkg::MdWidth-1:0]    md_i,
  input  wire kss_pkg::value_t                item_value_i,
  input  wire logic                           item_last_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output kss_pkg::value_t                     sorted_value_o,
  output logic                                sorted_last_o
);

  localparam int DEPTH = MAX_DISTANCE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = AW + 2;
  localparam int MW    = (CW > kss_pkg::MdWidth) ? CW : kss_pkg::MdWidth;

  kss_pkg::value_t heap_q [DEPTH];
  kss_pkg::value_t rd_a_q, rd_b_q;
  kss_pkg::value_t x_q, x_d;
  kss_pkg::value_t item_q;
  logic            last_q;
  logic [AW-1:0]   i_q, i_d;
  logic [AW:0]     c_q;
  logic [CW-1:0]   count_q, count_d;
  logic            out_valid_q;
  kss_pkg::value_t out_value_q;
  logic            out_last_q;

  logic [AW:0]     c_w;
  logic [XW-1:0]   count_ext;
  logic            right_ok, pick_right;
  kss_pkg::value_t s_val;
  logic [AW-1:0]   s_idx;
  logic [AW-1:0]   p_w;
  logic [AW-1:0]   cnt_m1;
  logic [AW-1:0]   ra, rb;
  logic            we;
  kss_pkg::value_t wd;
  logic            cap_hit;
  logic            sd_swap, su_swap;

  assign c_w        = {i_q, 1'b1};
  assign count_ext  = XW'(count_q);
  assign right_ok   = (XW'(c_q) + XW'(1)) < count_ext;
  assign pick_right = right_ok && (rd_b_q < rd_a_q);
  assign s_val      = pick_right ? rd_b_q : rd_a_q;
  assign s_idx      = pick_right ? (c_q[AW-1:0] + AW'(1)) : c_q[AW-1:0];
  assign p_w        = AW'((i_q - AW'(1)) >> 1);
  assign cnt_m1     = AW'(count_q - CW'(1));
  assign sd_swap    = s_val < x_q;
  assign su_swap    = x_q < rd_a_q;
  assign cap_hit    = int'(md_i) >= MAX_DISTANCE;

  always_comb begin
    stat_o            = '0;
    stat_o.need_pop   = (count_q >= CW'(DEPTH)) ||
                        (!cap_hit && (MW'(count_q) > MW'(md_i)));
    stat_o.count_zero = (count_q == '0);
    stat_o.sd_leaf    = XW'(c_w) >= count_ext;
    stat_o.sd_swap    = sd_swap;
    stat_o.su_root    = (i_q == '0);
    stat_o.su_swap    = su_swap;
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.item_last  = last_q;
  end

  // read addresses: root, last leaf on pop; children on sift-down; parent on sift-up
  always_comb begin
    ra = '0;
    rb = c_w[AW-1:0] + AW'(1);
    if (cmd_i.pop_read) begin
      rb = cnt_m1;
    end else if (cmd_i.sd_read) begin
      ra = c_w[AW-1:0];
    end else if (cmd_i.su_read) begin
      ra = p_w;
    end
  end

  // fill the hole at i_q: with the moved entry on a swap, else with the moving value
  always_comb begin
    we = 1'b0;
    wd = x_q;
    if (cmd_i.sd_step) begin
      we = 1'b1;
      wd = sd_swap ? s_val : x_q;
    end else if (cmd_i.su_step) begin
      we = 1'b1;
      wd = su_swap ? rd_a_q : x_q;
    end else if (cmd_i.wr_x) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_q[i_q] <= wd;
    end
    rd_a_q <= heap_q[ra];
    rd_b_q <= heap_q[rb];
  end

  always_comb begin
    i_d     = i_q;
    x_d     = x_q;
    count_d = count_q;
    if (cmd_i.pop_load) begin
      i_d     = '0;
      x_d     = rd_b_q;
      count_d = count_q - CW'(1);
    end else if (cmd_i.push_init) begin
      i_d     = AW'(count_q);
      x_d     = item_q;
      count_d = count_q + CW'(1);
    end else if (cmd_i.sd_step && sd_swap) begin
      i_d = s_idx;
    end else if (cmd_i.su_step && su_swap) begin
      i_d = p_w;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    x_q <= x_d;
    if (cmd_i.sd_read) begin
      c_q <= c_w;
    end
    if (cmd_i.load_item) begin
      item_q <= item_value_i;
      last_q <= item_last_i;
    end
    if (cmd_i.pop_load) begin
      out_value_q <= rd_a_q;
      out_last_q  <= cmd_i.drain && (count_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.pop_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign sorted_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ hdl/kss_ctrl.sv @@
// kss_ctrl: sequencer for accept, pop, sift-down, push, sift-up and drain.
// Depends on kss_pkg; issues commands to and reads status from kss_dp.
`default_nettype none

module kss_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire kss_pkg::dp_stat_t  stat_i,
  output kss_pkg::ctrl_cmd_t      cmd_o
);

  kss_pkg::state_e state_q, state_d;
  logic            drain_q, drain_d;
  kss_pkg::state_e after_pop;

  // after a pop: keep draining, finish, or go on to insert the new request
  always_comb begin
    if (drain_q) begin
      after_pop = stat_i.count_zero ? kss_pkg::ST_IDLE : kss_pkg::ST_POP_RD;
    end else begin
      after_pop = kss_pkg::ST_PUSH;
    end
  end

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    case (state_q)
      kss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = kss_pkg::ST_CHECK;
        end
      end
      kss_pkg::ST_CHECK: begin
        state_d = stat_i.need_pop ? kss_pkg::ST_POP_RD : kss_pkg::ST_PUSH;
      end
      kss_pkg::ST_POP_RD: begin
        if (stat_i.out_free) begin
          state_d = kss_pkg::ST_POP_LD;
        end
      end
      kss_pkg::ST_POP_LD: begin
        state_d = kss_pkg::ST_SD_RD;
      end
      kss_pkg::ST_SD_RD: begin
        state_d = stat_i.sd_leaf ? after_pop : kss_pkg::ST_SD_CMP;
        if (stat_i.sd_leaf && drain_q && stat_i.count_zero) begin
          drain_d = 1'b0;
        end
      end
      kss_pkg::ST_SD_CMP: begin
        state_d = stat_i.sd_swap ? kss_pkg::ST_SD_RD : after_pop;
        if (!stat_i.sd_swap && drain_q && stat_i.count_zero) begin
          drain_d = 1'b0;
        end
      end
      kss_pkg::ST_PUSH: begin
        state_d = kss_pkg::ST_SU_RD;
      end
      kss_pkg::ST_SU_RD: begin
        if (!stat_i.su_root) begin
          state_d = kss_pkg::ST_SU_CMP;
        end else if (stat_i.item_last) begin
          state_d = kss_pkg::ST_POP_RD;
          drain_d = 1'b1;
        end else begin
          state_d = kss_pkg::ST_IDLE;
        end
      end
      kss_pkg::ST_SU_CMP: begin
        if (stat_i.su_swap) begin
          state_d = kss_pkg::ST_SU_RD;
        end else if (stat_i.item_last) begin
          state_d = kss_pkg::ST_POP_RD;
          drain_d = 1'b1;
        end else begin
          state_d = kss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kss_pkg::ST_IDLE;
        drain_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kss_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      kss_pkg::ST_POP_RD: begin
        cmd_o.pop_read = stat_i.out_free;
      end
      kss_pkg::ST_POP_LD: begin
        cmd_o.pop_load = 1'b1;
        cmd_o.drain    = drain_q;
      end
      kss_pkg::ST_SD_RD: begin
        cmd_o.wr_x    = stat_i.sd_leaf;
        cmd_o.sd_read = !stat_i.sd_leaf;
      end
      kss_pkg::ST_SD_CMP: begin
        cmd_o.sd_step = 1'b1;
      end
      kss_pkg::ST_PUSH: begin
        cmd_o.push_init = 1'b1;
      end
      kss_pkg::ST_SU_RD: begin
        cmd_o.wr_x    = stat_i.su_root;
        cmd_o.su_read = !stat_i.su_root;
      end
      kss_pkg::ST_SU_CMP: begin
        cmd_o.su_step = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kss_pkg::ST_IDLE;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/k_sorted_stream_sorter.sv @@
// k_sorted_stream_sorter: top level; holds the max_distance register behind
// the APB port and joins kss_ctrl and kss_dp. Depends on kss_pkg, kss_in_if, kss_out_if.
//
//   port      dir  kind        payload
//   item_i    in   valid/ready item_value[31:0] signed, item_last
//   sorted_o  out  valid/ready sorted_value[31:0] signed, sorted_last
//   APB       in   psel/pen    max_distance at paddr 0 (4 bits, reset 1)
//
// One request at a time. A request is accepted in ST_IDLE and dispatched in
// ST_CHECK; a push then runs ST_PUSH and an ST_SU_RD/ST_SU_CMP pair per heap
// level climbed; a pop runs ST_POP_RD, which waits while the result register
// is held by sorted_o.ready, then ST_POP_LD and an ST_SD_RD/ST_SD_CMP pair per
// level sunk. A full heap holds 16 entries, all in a single heap memory.
// A final request adds one pop per stored value. Reset empties the heap at once.
`default_nettype none

module k_sorted_stream_sorter #(
  parameter int MAX_DISTANCE = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  kss_in_if.sink           item_i,
  kss_out_if.source        sorted_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [kss_pkg::MdWidth-1:0] md_q;
  logic                        cfg_wr;
  kss_pkg::ctrl_cmd_t          cmd;
  kss_pkg::dp_stat_t           stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == kss_pkg::RegMaxDistance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= kss_pkg::MdReset;
    end else if (cfg_wr) begin
      md_q <= pwdata[kss_pkg::MdWidth-1:0];
    end
  end

  assign prdata = (paddr[2] == kss_pkg::RegMaxDistance) ?
                  {{(32 - kss_pkg::MdWidth){1'b0}}, md_q} : '0;

  kss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kss_dp #(
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .md_i           (md_q),
    .item_value_i   (item_i.item_value),
    .item_last_i    (item_i.item_last),
    .out_ready_i    (sorted_o.ready),
    .out_valid_o    (sorted_o.valid),
    .sorted_value_o (sorted_o.sorted_value),
    .sorted_last_o  (sorted_o.sorted_last)
  );

endmodule

`default_nettype wire

@@ hdl/kss_checker.sv @@
// kss_checker: port-level checks for k_sorted_stream_sorter, bound to the top.
// Depends on kss_pkg and on the top level's ports only.
`default_nettype none

module kss_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire kss_pkg::value_t out_value_i,
  input wire logic            out_last_i,
  input wire logic            psel_i,
  input wire logic            penable_i,
  input wire logic            pwrite_i,
  input wire logic [2:0]      paddr_i,
  input wire logic [31:0]     pwdata_i,
  input wire logic [31:0]     prdata_i
);

  logic in_acc;
  logic cfg_wr;

  assign in_acc = in_valid_i && in_ready_i;
  assign cfg_wr = psel_i && penable_i && pwrite_i && (paddr_i[2] == kss_pkg::RegMaxDistance);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // one request at a time: drop ready right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("ready stayed high after accept");

  // a result never shows up in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // written window reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (paddr_i[2] != kss_pkg::RegMaxDistance) ||
               (prdata_i[kss_pkg::MdWidth-1:0] == $past(pwdata_i[kss_pkg::MdWidth-1:0])))
    else $error("max_distance readback mismatch");

endmodule

bind k_sorted_stream_sorter kss_checker u_kss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (sorted_o.valid),
  .out_ready_i (sorted_o.ready),
  .out_value_i (sorted_o.sorted_value),
  .out_last_i  (sorted_o.sorted_last),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for k_sorted_stream_sorter with a directed table and random streams.
// Depends on kss_pkg, kss_in_if, kss_out_if and the sorter RTL.
// Sorted results are checked against a multiset model that pops the minimum of the window.
`timescale 1ns / 100ps

module tb;

  localparam int MaxDistance = 15;
  localparam int HeapDepth = MaxDistance + 1;
  localparam int CycleLimit = 2_000_000;
  localparam int SettleCycles = 64;
  localparam int HoldOffCycles = 300;
  localparam int RandomItems = 340;
  localparam logic [2:0] AddrMaxDistance = {kss_pkg::RegMaxDistance, 2'b00};
  localparam logic [2:0] AddrUnmapped = {~kss_pkg::RegMaxDistance, 2'b00};
  localparam kss_pkg::value_t VMin = 32'sh8000_0000;
  localparam kss_pkg::value_t VMax = 32'sh7fff_ffff;
  localparam kss_pkg::value_t EdgeValues [7] =
    '{VMin, VMin + 1, -32'sd1, 32'sd0, 32'sd1, VMax - 1, VMax};

  typedef struct packed {
    kss_pkg::value_t value;
    logic            last;
  } sorted_res_t;

  typedef struct {
    bit              wr_cfg;
    logic [3:0]      cfg;
    kss_pkg::value_t value;
    logic            last;
    bit              typed;
    kss_pkg::value_t exp_value;
    logic            exp_last;
  } stim_row_t;

  // typed rows give the first result of that request by hand
  stim_row_t directed_rows [20] = '{
    '{1'b0, 4'd0,  VMin,    1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  VMax,    1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd0,  1'b0, 1'b1, VMin,   1'b0},
    '{1'b0, 4'd0,  -32'sd1, 1'b1, 1'b1, 32'sd0, 1'b0},
    '{1'b1, 4'd15, 32'sd5,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd3,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd3,  1'b1, 1'b1, 32'sd3, 1'b0},
    '{1'b0, 4'd0,  32'sd42, 1'b1, 1'b1, 32'sd42, 1'b1},
    '{1'b1, 4'd3,  32'sd10, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd9,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd8,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd7,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd6,  1'b0, 1'b1, 32'sd7, 1'b0},
    '{1'b0, 4'd0,  32'sd20, 1'b0, 1'b1, 32'sd6, 1'b0},
    '{1'b0, 4'd0,  32'sd100, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b1, 4'd0,  32'sd1,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd2,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  32'sd0,  1'b1, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  VMax,    1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 4'd0,  VMin,    1'b1, 1'b1, VMax,   1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kss_in_if  item_if ();
  kss_out_if sorted_if ();

  k_sorted_stream_sorter #(
    .MAX_DISTANCE(MaxDistance)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .sorted_o(sorted_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state
  kss_pkg::value_t heap_shadow[$];
  logic [3:0]      md_shadow;
  sorted_res_t     pending_sorted[$];

  int unsigned failures;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned stream_count;
  int unsigned cycle_count = 0;
  bit          steady_sender;
  bit          stall_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic kss_pkg::value_t pop_min_value();
    int unsigned     idx;
    kss_pkg::value_t v;
    idx = 0;
    for (int i = 1; i < heap_shadow.size(); i++) begin
      if (heap_shadow[i] < heap_shadow[idx]) idx = i;
    end
    v = heap_shadow[idx];
    heap_shadow.delete(idx);
    return v;
  endfunction

  function automatic void predict_sorted(kss_pkg::value_t v, logic last);
    int unsigned     win;
    kss_pkg::value_t m;
    sorted_res_t     r;
    win = ((int'(md_shadow) < MaxDistance) ? int'(md_shadow) : MaxDistance) + 1;
    // full (or over-full after a shrink) window: emit the minimum first
    if (heap_shadow.size() >= win || heap_shadow.size() >= HeapDepth) begin
      m = pop_min_value();
      r = '{value: m, last: 1'b0};
      pending_sorted.insert(pending_sorted.size(), r);
    end
    heap_shadow.insert(heap_shadow.size(), v);
    if (last) begin
      while (heap_shadow.size() > 0) begin
        m = pop_min_value();
        r = '{value: m, last: heap_shadow.size() == 0};
        pending_sorted.insert(pending_sorted.size(), r);
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (steady_sender) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one request, wait for it to be taken, then predict its results
  task automatic send_item(kss_pkg::value_t v, logic last, output int first_idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.item_value <= v;
    item_if.item_last  <= last;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
    items_sent++;
    first_idx = pending_sorted.size();
    predict_sorted(v, last);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_window_reg();
    logic [31:0] rd;
    apb_access(1'b0, AddrMaxDistance, 32'd0, rd);
    if (rd[3:0] !== md_shadow) begin
      $error("max_distance readback: expected %0d, got %0d", md_shadow, rd[3:0]);
      failures++;
    end
  endtask

  task automatic set_window(logic [3:0] md);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, AddrMaxDistance, {28'd0, md}, rd);
    md_shadow = md;
    check_window_reg();
  endtask

  task automatic run_stream(int unsigned len, bit tidy, bit shrink);
    kss_pkg::value_t vals[$];
    kss_pkg::value_t anchor;
    kss_pkg::value_t tmp;
    int unsigned     blk;
    int unsigned     hi;
    int unsigned     j;
    int              first_idx;
    anchor = $urandom;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:          vals.insert(vals.size(), EdgeValues[$urandom_range(0, 6)]);
        1, 2, 3, 4: vals.insert(vals.size(), anchor + kss_pkg::value_t'($urandom_range(0, 15)));
        default:    vals.insert(vals.size(), kss_pkg::value_t'($urandom));
      endcase
    end
    // keep every value within max_distance of its sorted place: shuffle per window
    if (tidy) begin
      vals.sort();
      blk = int'(md_shadow) + 1;
      for (int unsigned b = 0; b < len; b += blk) begin
        hi = ((b + blk < len) ? b + blk : len) - 1;
        for (int unsigned i = hi; i > b; i--) begin
          j = $urandom_range(b, i);
          tmp = vals[i];
          vals[i] = vals[j];
          vals[j] = tmp;
        end
      end
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (shrink && len > 1 && i == len / 2) set_window(4'($urandom_range(0, md_shadow)));
      send_item(vals[i], i == len - 1, first_idx);
    end
    stream_count++;
  endtask

  always @(posedge clk_i) begin
    sorted_res_t want;
    if (rst_ni && sorted_if.valid && sorted_if.ready) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected sorted result %0d last %0b",
               sorted_if.sorted_value, sorted_if.sorted_last);
        failures++;
      end else begin
        want = pending_sorted.pop_front();
        results_checked++;
        if (sorted_if.sorted_value !== want.value) begin
          $error("sorted_value: expected %0d, got %0d", want.value, sorted_if.sorted_value);
          failures++;
        end
        if (sorted_if.sorted_last !== want.last) begin
          $error("sorted_last: expected %0b, got %0b", want.last, sorted_if.sorted_last);
          failures++;
        end
      end
    end
  end

  // receiver: random ready runs, plus one long hold-off on request
  initial begin
    int unsigned run;
    int unsigned pick;
    bit          stall_done;
    stall_done      = 1'b0;
    sorted_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (stall_req && !stall_done) begin
        sorted_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        stall_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          sorted_if.ready <= 1'b1;
          run = $urandom_range(1, 24);
        end else if (pick < 93) begin
          sorted_if.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          sorted_if.ready <= 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] rd;
    int          first_idx;
    int unsigned len;
    logic [3:0]  md;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    item_if.valid      = 1'b0;
    item_if.item_value = '0;
    item_if.item_last  = 1'b0;
    md_shadow          = kss_pkg::MdReset;
    failures           = 0;
    items_sent         = 0;
    results_checked    = 0;
    stream_count       = 0;
    steady_sender      = 1'b0;
    stall_req          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unmapped write must leave max_distance at its reset value
    apb_access(1'b1, AddrUnmapped, 32'hffff_ffff, rd);
    check_window_reg();

    foreach (directed_rows[r]) begin
      if (directed_rows[r].wr_cfg) set_window(directed_rows[r].cfg);
      send_item(directed_rows[r].value, directed_rows[r].last, first_idx);
      if (directed_rows[r].typed) begin
        pending_sorted[first_idx] = '{value: directed_rows[r].exp_value,
                                      last: directed_rows[r].exp_last};
      end
    end
    wait_drained();

    // first random stream fills the full window while the output is held off
    set_window(4'd15);
    steady_sender = 1'b1;
    stall_req = 1'b1;
    run_stream(48, 1'b1, 1'b0);

    while (items_sent < $size(directed_rows) + RandomItems) begin
      case ($urandom_range(0, 3))
        0:       md = 4'd0;
        1:       md = 4'd15;
        default: md = 4'($urandom_range(0, 15));
      endcase
      set_window(md);
      steady_sender = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 2 * (int'(md) + 1) + 6);
      run_stream(len, $urandom_range(0, 4) != 0, $urandom_range(0, 5) == 0);
    end
    wait_drained();

    $display("Sent %0d requests in %0d random streams plus the directed table.",
             items_sent, stream_count);
    $display("%0d results checked; windows of 1 to 16, shrinks and a %0d-cycle hold-off.",
             results_checked, HoldOffCycles);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
